[hdl/sssd_pkg.sv]
// shared constants and codes for the seven-segment scan driver
`default_nettype none

package sssd_pkg;

    localparam int SLOT_TICKS_DEF   = 120;
    localparam int BLINK_FRAMES_DEF = 60;
    localparam int ON_STEPS         = 6;

    localparam int NUM_SLOTS   = 13;
    localparam int SLOT_W      = 4;
    localparam int SEG_W       = 8;
    localparam int STORE_DEPTH = 12;
    localparam int CFG_W       = 3;

    localparam logic [SEG_W-1:0]  SEG_BLANK    = 8'hff;
    localparam logic [2:0]        BRIGHT_MAX   = 3'd6;
    localparam logic [SLOT_W-1:0] SLOT_IND     = 4'd12;
    localparam logic [SLOT_W-1:0] SLOT_ROW0    = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_ROW2    = 4'd4;
    localparam logic [SLOT_W-1:0] ROW1_OFFSET  = 4'd4;

    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_WRITE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        CFG_BRIGHTNESS = 2'd0,
        CFG_FLASH_EN   = 2'd1,
        CFG_FLASH_POS  = 2'd2,
        CFG_NONE       = 2'd3
    } t_cfg_index;

    localparam logic [1:0] ROW_IND     = 2'd3;
    localparam logic [1:0] COL_IND_SEG = 2'd0;
    localparam logic [1:0] COL_IND_LED = 2'd1;

endpackage

`default_nettype wire

[hdl/seven_segment_scan_driver.sv]
// multiplexed seven-segment scan driver: digit store, slot timing, blink and output register
//
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall   i_action, i_row, i_column, i_seg_value
// out       output     o_out_valid / i_out_stall o_segments, o_slot, o_extra_led, o_frame_start
// cfg       input      i_cfg_wr_en               i_cfg_idx, i_cfg_wdata
//
// one beat per clock while the input is not stalled: a write updates the store, a tick registers one result
// the result register is the only stage; a new beat is taken while it drains the old one
// input stalls only when the result register is full and the output is stalled
// synchronous active-low reset blanks the store, resets counters and sets brightness to 6
`default_nettype none

module seven_segment_scan_driver #(
    parameter int SLOT_TICKS   = sssd_pkg::SLOT_TICKS_DEF,
    parameter int BLINK_FRAMES = sssd_pkg::BLINK_FRAMES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [1:0]                 i_cfg_idx,
    input  wire logic [sssd_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic                       i_action,
    input  wire logic [1:0]                 i_row,
    input  wire logic [1:0]                 i_column,
    input  wire logic [sssd_pkg::SEG_W-1:0] i_seg_value,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [sssd_pkg::SEG_W-1:0]      o_segments,
    output logic [sssd_pkg::SLOT_W-1:0]     o_slot,
    output logic                            o_extra_led,
    output logic                            o_frame_start
);
    import sssd_pkg::*;

    localparam int TICK_W  = $clog2(SLOT_TICKS + 1);
    localparam int BF_W    = (BLINK_FRAMES > 2) ? $clog2(BLINK_FRAMES) : 1;
    localparam int ON_STEP = SLOT_TICKS / ON_STEPS;

    // configuration
    logic [2:0] r_brightness;
    logic       r_flash_en;
    logic [1:0] r_flash_pos;

    // display state
    logic [SEG_W-1:0]  r_store [STORE_DEPTH];
    logic [SEG_W-1:0]  r_ind_seg;
    logic              r_ind_led;
    logic [SLOT_W-1:0] r_slot;
    logic [TICK_W-1:0] r_tick;
    logic [BF_W-1:0]   r_blink_frames;
    logic              r_blink_phase;

    // result register
    logic              r_out_valid;
    logic [SEG_W-1:0]  r_segments;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_extra_led;
    logic              r_frame_start;

    logic              w_accept;
    logic              w_tick;
    logic              w_write;
    logic              w_first;
    logic [TICK_W-1:0] w_on_ticks;
    logic [SLOT_W-1:0] w_store_idx;
    logic [SEG_W-1:0]  n_segments;
    logic              n_extra_led;
    logic [BF_W-1:0]   n_blink_frames;
    logic              n_blink_phase;
    logic [TICK_W-1:0] n_tick;
    logic [SLOT_W-1:0] n_slot;
    logic              w_blank_digit;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_tick     = w_accept & (i_action == ACT_TICK);
    assign w_write    = w_accept & (i_action == ACT_WRITE);

    assign w_first    = (r_slot == '0) && (r_tick == '0);
    assign w_on_ticks = TICK_W'(ON_STEP * int'(r_brightness));

    // row 1 first, then row 2, then row 0
    assign w_store_idx = (r_slot < SLOT_ROW0) ? (r_slot + ROW1_OFFSET) : (r_slot - SLOT_ROW0);

    always_comb begin
        n_blink_frames = r_blink_frames;
        n_blink_phase  = r_blink_phase;
        if (w_first && r_flash_en) begin
            if (r_blink_frames == BF_W'(BLINK_FRAMES - 1)) begin
                n_blink_frames = '0;
                n_blink_phase  = ~r_blink_phase;
            end else begin
                n_blink_frames = r_blink_frames + 1'b1;
            end
        end
    end

    // blanking uses the phase as updated on this very tick
    assign w_blank_digit = r_flash_en && n_blink_phase && (r_slot >= SLOT_ROW2)
                           && (r_slot < SLOT_ROW0)
                           && (r_slot[1:0] == r_flash_pos);

    always_comb begin
        n_segments  = SEG_BLANK;
        n_extra_led = 1'b1;
        if (r_tick < w_on_ticks) begin
            if (r_slot < SLOT_IND) begin
                n_segments = w_blank_digit ? SEG_BLANK : r_store[w_store_idx];
            end else begin
                n_segments  = r_ind_seg;
                n_extra_led = r_ind_led;
            end
        end
    end

    always_comb begin
        n_tick = r_tick + 1'b1;
        n_slot = r_slot;
        if (r_tick == TICK_W'(SLOT_TICKS - 1)) begin
            n_tick = '0;
            n_slot = (r_slot == SLOT_W'(NUM_SLOTS - 1)) ? '0 : (r_slot + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= BRIGHT_MAX;
            r_flash_en   <= 1'b0;
            r_flash_pos  <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_idx))
                CFG_BRIGHTNESS: begin
                    if (i_cfg_wdata <= BRIGHT_MAX) begin
                        r_brightness <= i_cfg_wdata;
                    end
                end
                CFG_FLASH_EN:  r_flash_en  <= i_cfg_wdata[0];
                CFG_FLASH_POS: r_flash_pos <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_store[i] <= SEG_BLANK;
            end
            r_ind_seg <= SEG_BLANK;
            r_ind_led <= 1'b1;
        end else if (w_write) begin
            if (i_row != ROW_IND) begin
                r_store[{i_row, i_column}] <= i_seg_value;
            end else if (i_column == COL_IND_SEG) begin
                r_ind_seg <= i_seg_value;
            end else if (i_column == COL_IND_LED) begin
                r_ind_led <= i_seg_value[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot         <= '0;
            r_tick         <= '0;
            r_blink_frames <= '0;
            r_blink_phase  <= 1'b0;
        end else if (w_tick) begin
            r_slot         <= n_slot;
            r_tick         <= n_tick;
            r_blink_frames <= n_blink_frames;
            r_blink_phase  <= n_blink_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tick) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_segments    <= n_segments;
            r_out_slot    <= r_slot;
            r_extra_led   <= n_extra_led;
            r_frame_start <= w_first;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_segments    = r_segments;
    assign o_slot        = r_out_slot;
    assign o_extra_led   = r_extra_led;
    assign o_frame_start = r_frame_start;

    a_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick < TICK_W'(SLOT_TICKS) && r_slot < SLOT_W'(NUM_SLOTS))
        else $error("slot timing counter out of range");

    a_frame_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_start) |-> (o_slot == '0))
        else $error("frame start outside slot zero");

    a_led_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_extra_led) |-> (o_slot == SLOT_IND))
        else $error("extra led lit outside indicator slot");

    a_phase_flash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_blink_phase) |-> $past(r_flash_en && w_tick && w_first))
        else $error("blink phase moved without a flashing frame start");

    a_result_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick) |=> (o_out_valid && o_slot == $past(r_slot)))
        else $error("tick beat did not load the result register");

endmodule

`default_nettype wire
